FILE: src/crcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcl_pkg : shared types and constants of the CRC-32 length trailer block
// Holds the generator polynomial and the request bundle for the byte step.
// ----------------------------------------------------------------------------
package crcl_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam int          CRC_W    = 32;
    localparam int          BYTE_W   = 8;

    // one request to the shared byte step unit
    typedef struct packed {
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] data;
    } t_step_req;

endpackage
`default_nettype wire

FILE: src/crcl_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcl_step : one byte of MSB-first CRC-32
// Folds one byte into the running remainder, eight polynomial steps.
// ----------------------------------------------------------------------------
module crcl_step
    import crcl_pkg::*;
(
    input  wire t_step_req        i_req,
    output logic [CRC_W-1:0]      o_crc
);

    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_req.crc ^ {i_req.data, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule
`default_nettype wire

FILE: src/crc32_with_length_trailer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_with_length_trailer : CRC-32 over a byte stream with a length trailer
// Absorbs message bytes, then on the closing item appends the byte count
// (least significant byte first, leading zero bytes dropped) and emits the CRC.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata = data_byte, tuser = has_byte,
//                                        tlast = last
//  m_axis    out  tvalid / tready        tdata = checksum
//
//  An item without tlast is taken at once; the next may follow at once.
//  A closing item is followed by its n significant length bytes (0 to 4),
//  each folded in by the single shared byte step unit, before the result is emitted.
//  The result sits in an output register; a stall there holds the block only
//  when a second result is ready before the first has been taken.
//  Reset (synchronous, active low) clears CRC, count, state and output valid.
// ----------------------------------------------------------------------------
module crc32_with_length_trailer
    import crcl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tuser,   // [0] has_byte
    input  wire         i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] checksum
);

    localparam logic S_IDLE = 1'b0;   // taking message items
    localparam logic S_LEN  = 1'b1;   // folding in length bytes

    logic             r_state, n_state;
    logic [CRC_W-1:0] r_crc, n_crc;
    logic [CRC_W-1:0] r_count, n_count;
    logic [CRC_W-1:0] r_len, n_len;
    logic             r_out_valid, n_out_valid;
    logic [CRC_W-1:0] r_out_data, n_out_data;

    t_step_req        step_req;
    logic [CRC_W-1:0] step_crc;
    logic             in_fire;
    logic             out_free;

    // the one byte step unit, shared by message and length bytes
    crcl_step u_step (
        .i_req (step_req),
        .o_crc (step_crc)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    always_comb begin
        step_req.crc  = r_crc;
        step_req.data = (r_state == S_IDLE) ? i_s_axis_tdata : r_len[BYTE_W-1:0];

        n_state     = r_state;
        n_crc       = r_crc;
        n_count     = r_count;
        n_len       = r_len;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_m_axis_tready;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // absorb and count the byte first, close afterwards
                    if (i_s_axis_tuser) begin
                        n_crc   = step_crc;
                        n_count = r_count + 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_len   = n_count;
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (r_len != '0) begin
                    // fold in the next length byte, drop it from the count
                    n_crc = step_crc;
                    n_len = r_len >> BYTE_W;
                end else if (out_free) begin
                    // emit and start a fresh message
                    n_out_data  = r_crc;
                    n_out_valid = 1'b1;
                    n_crc       = '0;
                    n_count     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_crc       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

FILE: src/crcl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcl_checker : port level checks of the CRC-32 length trailer block
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module crcl_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        i_s_axis_tready,
    input wire        i_s_axis_tlast,
    input wire        i_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [31:0] i_m_axis_tdata
);

    logic s_fire;
    assign s_fire = i_s_axis_tvalid && i_s_axis_tready;

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("stalled result changed");

    // a closing item blocks input while the trailer is folded in
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && i_s_axis_tlast |=> !i_s_axis_tready)
        else $error("input taken during trailer");

    // a message item leaves the input ready
    a_byte_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && !i_s_axis_tlast |=> i_s_axis_tready)
        else $error("input stalled after message item");

    // a new result only appears at the end of a trailer pass
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_axis_tvalid) |-> $past(!i_s_axis_tready))
        else $error("result without closing item");

endmodule

bind crc32_with_length_trailer crcl_checker u_crcl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
